@@ rtl/stq_pkg.sv @@
package stq_pkg;

    localparam int DefaultTimerSlots = 16;
    localparam int ResultLimit       = 16;

    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_DESTROY  = 3'd1;
    localparam logic [2:0] OP_RESET    = 3'd2;
    localparam logic [2:0] OP_SET_INTV = 3'd3;
    localparam logic [2:0] OP_CHECK    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_NOT_USE = 2'd2;

    // command passed from the front end to the execution engine
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic        periodic;
        logic [31:0] interval;
        logic [31:0] now;
    } cmd_t;

endpackage

@@ rtl/sorted_timer_queue_unit.sv @@
// Sorted timer queue: 16-slot table by default, one operation per transaction.
// Destroy/reset/set interval: table updated in S_IDLE, result presented from S_OUT, engine idle.
// Create: the sequential free-slot walk in S_SCAN takes the lowest free slot.
// Check: a pass marks due slots, then a full pass over the slots picks each fired result.
// A 2-entry command queue buffers input; the engine takes one once its result is taken.
// Synchronous active-low reset clears all slots to free and unexpired.
module sorted_timer_queue_unit #(
    parameter int TIMER_SLOTS = stq_pkg::DefaultTimerSlots
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [3:0]  s_slot,
    input  logic        s_periodic,
    input  logic [31:0] s_interval,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_result_slot,
    output logic        m_fired,
    output logic        m_last
);

    logic          cmd_valid, cmd_ready;
    stq_pkg::cmd_t cmd;

    stq_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation, .s_slot,
        .s_periodic, .s_interval, .s_now, .cmd_valid, .cmd_ready, .cmd
    );

    stq_engine #(.TIMER_SLOTS(TIMER_SLOTS)) u_engine (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd, .m_valid, .m_ready,
        .m_status, .m_result_slot, .m_fired, .m_last
    );

endmodule

@@ rtl/stq_front.sv @@
module stq_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic [3:0]         s_slot,
    input  logic               s_periodic,
    input  logic [31:0]        s_interval,
    input  logic [31:0]        s_now,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output stq_pkg::cmd_t      cmd
);

    // two-entry command queue
    stq_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign s_ready   = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{op: s_operation, slot: s_slot, periodic: s_periodic,
                                   interval: s_interval, now: s_now};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> !s_ready)
        else $error("full queue accepted");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !cmd_valid)
        else $error("empty queue presented command");

endmodule

@@ rtl/stq_engine.sv @@
module stq_engine #(
    parameter int TIMER_SLOTS = stq_pkg::DefaultTimerSlots
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  stq_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [3:0]         m_result_slot,
    output logic               m_fired,
    output logic               m_last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(stq_pkg::ResultLimit + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CSCAN = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIRE  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // slot table
    logic [TIMER_SLOTS-1:0] in_use_reg, expired_reg, repeats_reg, due_reg;
    logic [31:0]            start_reg  [TIMER_SLOTS];
    logic [31:0]            period_reg [TIMER_SLOTS];

    logic [2:0]    state_reg;
    stq_pkg::cmd_t c_reg;
    logic [SW:0]   idx_reg;
    logic [SW-1:0] best_reg;
    logic          found_reg;
    logic [39:0]   best_ov_reg;
    logic [CW-1:0] nfired_reg;

    // output register
    logic       ov_reg;
    logic [1:0] os_reg;
    logic [3:0] oslot_reg;
    logic       of_reg, ol_reg;
    logic       ov_load;

    assign m_valid       = ov_reg;
    assign m_status      = os_reg;
    assign m_result_slot = oslot_reg;
    assign m_fired       = of_reg;
    assign m_last        = ol_reg;
    // next command only once the result register is free
    assign cmd_ready     = (state_reg == S_IDLE) && !ov_reg;

    logic [SW-1:0] idx;
    logic [39:0]   scaled, overdue;
    logic          cur_due;
    logic          slot_ok;
    logic [SW-1:0] cslot;
    assign idx     = idx_reg[SW-1:0];
    assign scaled  = {c_reg.now - start_reg[idx], 8'd0};
    assign overdue = scaled - {8'd0, period_reg[idx]};
    assign cur_due = in_use_reg[idx] && !expired_reg[idx] &&
                     (scaled >= {8'd0, period_reg[idx]});
    assign slot_ok = (32'(cmd.slot) < 32'(TIMER_SLOTS)) && in_use_reg[SW'(cmd.slot)];
    assign cslot   = SW'(cmd.slot);

    // result register load: reply in S_OUT, fire or empty check at end of a pass
    always_comb begin
        ov_load = 1'b0;
        if (!ov_reg || m_ready) begin
            if (state_reg == S_OUT) begin
                ov_load = 1'b1;
            end else if (state_reg == S_FIRE && idx_reg == (SW+1)'(TIMER_SLOTS)) begin
                ov_load = (found_reg && nfired_reg != CW'(stq_pkg::ResultLimit)) ||
                          (nfired_reg == '0);
            end
        end
    end

    function automatic logic [3:0] low4(input logic [SW-1:0] v);
        logic [SW+3:0] w;
        w = {4'd0, v};
        return w[3:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            expired_reg <= '0;
            due_reg     <= '0;
            ov_reg      <= 1'b0;
        end else begin
            if (ov_load) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        c_reg <= cmd;
                        if (cmd.op == stq_pkg::OP_CHECK) begin
                            idx_reg    <= '0;
                            nfired_reg <= '0;
                            state_reg  <= S_CSCAN;
                        end else begin
                            os_reg    <= stq_pkg::ST_OK;
                            oslot_reg <= 4'd0;
                            of_reg    <= 1'b0;
                            ol_reg    <= 1'b1;
                            idx_reg   <= '0;
                            state_reg <= (cmd.op == stq_pkg::OP_CREATE) ? S_SCAN : S_OUT;
                            if (cmd.op == stq_pkg::OP_DESTROY ||
                                cmd.op == stq_pkg::OP_RESET ||
                                cmd.op == stq_pkg::OP_SET_INTV) begin
                                if (!slot_ok) begin
                                    os_reg <= stq_pkg::ST_NOT_USE;
                                end else if (cmd.op == stq_pkg::OP_DESTROY) begin
                                    in_use_reg[cslot]  <= 1'b0;
                                    expired_reg[cslot] <= 1'b0;
                                end else if (cmd.op == stq_pkg::OP_RESET) begin
                                    start_reg[cslot]   <= cmd.now;
                                    expired_reg[cslot] <= 1'b0;
                                end else begin
                                    period_reg[cslot] <= cmd.interval;
                                end
                            end
                        end
                    end
                end
                // create: walk for lowest free slot
                S_SCAN: begin
                    if (idx_reg == (SW+1)'(TIMER_SLOTS)) begin
                        os_reg    <= stq_pkg::ST_NO_SLOT;
                        state_reg <= S_OUT;
                    end else if (!in_use_reg[idx]) begin
                        in_use_reg[idx]  <= 1'b1;
                        expired_reg[idx] <= 1'b0;
                        repeats_reg[idx] <= c_reg.periodic;
                        start_reg[idx]   <= c_reg.now;
                        period_reg[idx]  <= c_reg.interval;
                        oslot_reg        <= low4(idx);
                        state_reg        <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // check: mark due slots, one per cycle
                S_CSCAN: begin
                    due_reg[idx] <= cur_due;
                    if (idx_reg == (SW+1)'(TIMER_SLOTS - 1)) begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_FIRE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // pick most overdue, lowest slot on ties
                S_FIRE: begin
                    if (idx_reg == (SW+1)'(TIMER_SLOTS)) begin
                        if (!ov_reg || m_ready) begin
                            if (!found_reg || nfired_reg == CW'(stq_pkg::ResultLimit)) begin
                                if (nfired_reg == '0) begin
                                    os_reg    <= stq_pkg::ST_OK;
                                    oslot_reg <= 4'd0;
                                    of_reg    <= 1'b0;
                                    ol_reg    <= 1'b1;
                                end
                                due_reg   <= '0;
                                state_reg <= S_IDLE;
                            end else begin
                                due_reg[best_reg] <= 1'b0;
                                if (repeats_reg[best_reg]) begin
                                    start_reg[best_reg] <= c_reg.now;
                                end else begin
                                    expired_reg[best_reg] <= 1'b1;
                                end
                                os_reg     <= stq_pkg::ST_OK;
                                oslot_reg  <= low4(best_reg);
                                of_reg     <= 1'b1;
                                ol_reg     <= (nfired_reg == CW'(stq_pkg::ResultLimit - 1)) ||
                                              ($countones(due_reg) == 1);
                                nfired_reg <= nfired_reg + 1'b1;
                                idx_reg    <= '0;
                                found_reg  <= 1'b0;
                            end
                        end
                    end else begin
                        if (due_reg[idx] && (!found_reg || overdue > best_ov_reg)) begin
                            best_reg    <= idx;
                            best_ov_reg <= overdue;
                            found_reg   <= 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!ov_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_result_slot))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (due_reg == '0))
        else $error("due marks left after check");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (expired_reg & ~in_use_reg) == '0)
        else $error("expired mark on free slot");

endmodule
